// ===== src/dacs_value_chunk_encoder_top_defines.svh =====
// Assertion macros for the encoder's RTL, used by dacs_back.
// Relies on clk and arst_n in the module that uses them.
`ifndef DACS_VALUE_CHUNK_ENCODER_TOP_DEFINES_SVH
`define DACS_VALUE_CHUNK_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DACS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DACS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DACS_ASSERT(lbl, prop, msg)
`define DACS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== src/dacs_pkg.sv =====
// Shared types, constants and helpers for the DACs chunk encoder.
// No dependencies.
package dacs_pkg;

	localparam int MAX_LEVELS  = 8;
	localparam int VALUE_BITS  = 32;
	localparam int LVL_W       = $clog2(MAX_LEVELS);
	localparam int CW_FIELD    = 5;
	localparam int CW_BITS     = 40;
	localparam int LC_W        = 4;
	localparam int CHUNK_W     = 31;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 40;
	localparam int EXPO_W      = 8;
	localparam int SH_W        = $clog2(VALUE_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_WIDTHS = CFG_IDX_W'(1);

	localparam logic [LC_W-1:0]    LC_RESET = LC_W'(8);
	localparam logic [CW_BITS-1:0] CW_RESET = CW_BITS'(64'd141872468100);

	typedef logic [LVL_W-1:0]      lvl_t;
	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [CW_BITS-1:0]    cw_t;
	typedef logic [CW_FIELD-1:0]   width_t;

	typedef struct packed {
		lvl_t top;
		cw_t  widths;
	} cfg_t;

	typedef struct packed {
		logic [MAX_LEVELS-1:1] ok;
		val_t [MAX_LEVELS-1:1] base;
	} btab_t;

	typedef struct packed {
		val_t rem;
		lvl_t sel;
	} work_t;

	// width field of a level, a zero field reads as one bit
	function automatic width_t chunk_width(cw_t widths, lvl_t lvl);
		width_t w;
		w = widths[CW_FIELD*lvl +: CW_FIELD];
		return (w == '0) ? width_t'(1) : w;
	endfunction

endpackage

// ===== src/dacs_value_chunk_encoder_top.sv =====
// DACs value chunk encoder: splits each 32-bit value into one chunk per level up to its
// own level, low bits first, with level, width, stop bit, overflow and last flags. The
// back end emits one chunk per cycle unless chunk_ready stalls it, j+1 chunks for a
// value of level j; a value passes the front stage, queue and work register, then the
// output register. The front end compares a value against all level bases at once and
// takes one value a cycle unless a rebuild or full queue holds it. Reset and each
// configuration write rebuild the base table one level a cycle, with value_ready low.
// Depends on dacs_pkg and dacs_cfg, dacs_front, dacs_queue, dacs_back.
module dacs_value_chunk_encoder_top import dacs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  value_valid,
	output logic                  value_ready,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  chunk_valid,
	input  logic                  chunk_ready,
	output logic [LVL_W-1:0]      level,
	output logic [CHUNK_W-1:0]    chunk,
	output logic [CW_FIELD-1:0]   chunk_bits,
	output logic                  has_mark,
	output logic                  stop_mark,
	output logic                  overflow,
	output logic                  last
);

	cfg_t  cfg;
	btab_t tab;
	logic  busy;
	logic  push_valid;
	logic  push_ready;
	work_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	work_t pop_data;

	dacs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.tab      (tab),
		.busy     (busy)
	);

	dacs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.busy        (busy),
		.tab         (tab),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	dacs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dacs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.chunk_valid (chunk_valid),
		.chunk_ready (chunk_ready),
		.level       (level),
		.chunk       (chunk),
		.chunk_bits  (chunk_bits),
		.has_mark    (has_mark),
		.stop_mark   (stop_mark),
		.overflow    (overflow),
		.last        (last)
	);

endmodule

// ===== src/dacs_cfg.sv =====
// Configuration registers and level base table sweep.
// Depends on dacs_pkg.
module dacs_cfg import dacs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                 cfg,
	output btab_t                tab,
	output logic                 busy
);

	logic [LC_W-1:0]       lc_q;
	cw_t                   cw_q;
	logic                  busy_q;
	lvl_t                  k_q;
	logic [EXPO_W-1:0]     expo_q;
	val_t                  acc_q;
	logic                  ok_acc_q;
	logic [MAX_LEVELS-1:1] ok_q;
	val_t [MAX_LEVELS-1:1] base_q;

	logic [LC_W-1:0]       n_lev;
	logic [EXPO_W-1:0]     expo_n;
	logic [VALUE_BITS:0]   sum;
	logic                  ok_n;

	always_comb begin
		if (lc_q == '0) begin
			n_lev = LC_W'(1);
		end else if (lc_q > LC_W'(MAX_LEVELS)) begin
			n_lev = LC_W'(MAX_LEVELS);
		end else begin
			n_lev = lc_q;
		end
	end

	// base[k] = base[k-1] + 2^(w[0]+..+w[k-1]), one level a cycle
	assign expo_n = expo_q + EXPO_W'(chunk_width(cw_q, k_q - lvl_t'(1)));
	assign sum    = {1'b0, acc_q} + ((VALUE_BITS+1)'(1) << expo_n[SH_W-1:0]);
	assign ok_n   = ok_acc_q && ({1'b0, k_q} < n_lev) &&
		(expo_n < EXPO_W'(VALUE_BITS)) && !sum[VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q     <= LC_RESET;
			cw_q     <= CW_RESET;
			busy_q   <= 1'b1;
			k_q      <= lvl_t'(1);
			expo_q   <= '0;
			acc_q    <= '0;
			ok_acc_q <= 1'b1;
			ok_q     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LEVEL_COUNT:  lc_q <= wr_data[LC_W-1:0];
				REG_CHUNK_WIDTHS: cw_q <= wr_data[CW_BITS-1:0];
				default: ;
			endcase
			busy_q   <= 1'b1;
			k_q      <= lvl_t'(1);
			expo_q   <= '0;
			acc_q    <= '0;
			ok_acc_q <= 1'b1;
		end else if (busy_q) begin
			expo_q    <= expo_n;
			acc_q     <= sum[VALUE_BITS-1:0];
			ok_acc_q  <= ok_n;
			ok_q[k_q] <= ok_n;
			if (k_q == lvl_t'(MAX_LEVELS-1)) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + lvl_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !wr_en) begin
			base_q[k_q] <= sum[VALUE_BITS-1:0];
		end
	end

	assign cfg.top    = lvl_t'(n_lev - LC_W'(1));
	assign cfg.widths = cw_q;
	assign tab.ok     = ok_q;
	assign tab.base   = base_q;
	assign busy       = busy_q || wr_en;

endmodule

// ===== src/dacs_front.sv =====
// Front end: takes a value, finds its level and subtracts the level base.
// Depends on dacs_pkg.
module dacs_front import dacs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  value_valid,
	output logic  value_ready,
	input  val_t  value,
	input  logic  busy,
	input  btab_t tab,
	output logic  push_valid,
	input  logic  push_ready,
	output work_t push_data
);

	logic                  v_s1;
	val_t                  value_s1;
	logic [MAX_LEVELS-1:1] hit_s1;
	logic [MAX_LEVELS-1:1] hit_d;
	lvl_t                  sel;
	val_t                  selbase;
	logic                  run;

	always_comb begin
		for (int i = 1; i < MAX_LEVELS; i++) begin
			hit_d[i] = tab.ok[i] && (value >= tab.base[i]);
		end
	end

	assign value_ready = !busy && (!v_s1 || push_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (value_ready) begin
			v_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (value_valid && value_ready) begin
			value_s1 <= value;
			hit_s1   <= hit_d;
		end
	end

	// bases rise with the level, so the hits form a run from level one
	always_comb begin
		sel     = '0;
		selbase = '0;
		run     = 1'b1;
		for (int i = 1; i < MAX_LEVELS; i++) begin
			run = run && hit_s1[i];
			if (run) begin
				sel     = lvl_t'(i);
				selbase = tab.base[i];
			end
		end
	end

	assign push_valid    = v_s1;
	assign push_data.rem = value_s1 - selbase;
	assign push_data.sel = sel;

endmodule

// ===== src/dacs_queue.sv =====
// Short queue between front and back ends.
// Depends on dacs_pkg.
module dacs_queue import dacs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	work_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== src/dacs_back.sv =====
// Back end: peels one chunk a cycle, while not stalled, off the remainder into
// the output register. Depends on dacs_pkg and the assertion macro header.
`include "dacs_value_chunk_encoder_top_defines.svh"
module dacs_back import dacs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  work_t              pop_data,
	output logic               chunk_valid,
	input  logic               chunk_ready,
	output lvl_t               level,
	output logic [CHUNK_W-1:0] chunk,
	output width_t             chunk_bits,
	output logic               has_mark,
	output logic               stop_mark,
	output logic               overflow,
	output logic               last
);

	logic   work_v_q;
	val_t   rem_q;
	lvl_t   lvl_q;
	lvl_t   sel_q;
	logic   out_v_q;

	width_t w;
	val_t   mask;
	val_t   rem_sh;
	logic   fin;
	logic   mark;
	logic   out_en;
	logic   pop;

	assign w      = chunk_width(cfg.widths, lvl_q);
	assign mask   = (val_t'(1) << w) - val_t'(1);
	assign rem_sh = rem_q >> w;
	assign fin    = lvl_q == sel_q;
	assign mark   = lvl_q < cfg.top;
	assign out_en = work_v_q && (!out_v_q || chunk_ready);
	assign pop    = pop_valid && (!work_v_q || (out_en && fin));

	assign pop_ready   = pop;
	assign chunk_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				work_v_q <= 1'b1;
			end else if (out_en && fin) begin
				work_v_q <= 1'b0;
			end
			if (out_en) begin
				out_v_q <= 1'b1;
			end else if (chunk_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= pop_data.rem;
			sel_q <= pop_data.sel;
			lvl_q <= '0;
		end else if (out_en) begin
			rem_q <= rem_sh;
			lvl_q <= lvl_q + lvl_t'(1);
		end
		if (out_en) begin
			level      <= lvl_q;
			chunk      <= CHUNK_W'(rem_q & mask);
			chunk_bits <= w;
			has_mark   <= mark;
			stop_mark  <= fin && mark;
			overflow   <= fin && !mark && (rem_sh != '0);
			last       <= fin;
		end
	end

	`DACS_ASSERT(a_lvl_within_sel, work_v_q |-> (lvl_q <= sel_q), "level ran past selected level")
	`DACS_ASSERT(a_done_goes_idle, (out_en && fin && !pop) |=> !work_v_q, "work kept after last chunk")
	`DACS_ASSERT(a_load_level_zero, pop |=> (work_v_q && lvl_q == '0), "new item not at level zero")

endmodule

// ===== bench/dacs_chunk_checker.sv =====
// Scoreboard for the DACs value chunk encoder: tracks register writes, predicts
// the chunk sequence of every accepted value and compares each accepted chunk.
// Depends on dacs_pkg.
`timescale 1ns / 1ps

module dacs_chunk_checker import dacs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  value_valid,
	input  logic                  value_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  chunk_valid,
	input  logic                  chunk_ready,
	input  logic [LVL_W-1:0]      level,
	input  logic [CHUNK_W-1:0]    chunk,
	input  logic [CW_FIELD-1:0]   chunk_bits,
	input  logic                  has_mark,
	input  logic                  stop_mark,
	input  logic                  overflow,
	input  logic                  last,
	output int                    errors,
	output int                    pending
);

	localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct packed {
		lvl_t                level;
		logic [CHUNK_W-1:0]  chunk;
		width_t              bits;
		logic                has_mark;
		logic                stop_mark;
		logic                overflow;
		logic                last;
	} chunk_rec_t;

	chunk_rec_t      chunk_q[$];
	logic [LC_W-1:0] lc_copy = LC_RESET;
	cw_t             cw_copy = CW_RESET;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic width_t level_width(int unsigned k);
		width_t w;
		w = cw_copy[CW_FIELD*((k > 7) ? 7 : k) +: CW_FIELD];
		return (w == '0) ? width_t'(1) : w;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		if (errors < 100)
			$display("%0t: chunk mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	// pick the highest reachable level whose base the value reaches, then split
	task automatic predict_chunks(val_t v);
		int unsigned nlev, top_lvl, sel, expo;
		logic [63:0] base, selbase, nb, rem;
		width_t      w;
		chunk_rec_t  rec;
		nlev = (lc_copy == '0) ? 1 : ((lc_copy > MAX_LEVELS) ? MAX_LEVELS : lc_copy);
		top_lvl = nlev - 1;
		sel = 0;
		selbase = '0;
		base = '0;
		expo = 0;
		for (int unsigned i = 1; i < nlev; i++) begin
			expo += 32'(level_width(i - 1));
			if (expo >= VALUE_BITS)
				break;
			nb = base + (64'd1 << expo);
			if (nb > VALUE_MAX)
				break;
			base = nb;
			if (64'(v) >= base) begin
				sel = i;
				selbase = base;
			end else
				break;
		end
		rem = 64'(v) - selbase;
		for (int unsigned i = 0; i <= sel; i++) begin
			w = level_width(i);
			rec.level = lvl_t'(i);
			rec.chunk = CHUNK_W'(rem & ((64'd1 << w) - 64'd1));
			rec.bits = w;
			rem = rem >> w;
			rec.has_mark = (i < top_lvl);
			rec.last = (i == sel);
			rec.stop_mark = rec.last && rec.has_mark;
			// top level keeps only its own width, anything left is lost
			rec.overflow = rec.last && !rec.has_mark && (rem != '0);
			chunk_q.push_back(rec);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		chunk_rec_t want;
		if (!arst_n) begin
			lc_copy = LC_RESET;
			cw_copy = CW_RESET;
			chunk_q.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LEVEL_COUNT:  lc_copy = cfg_data[LC_W-1:0];
					REG_CHUNK_WIDTHS: cw_copy = cfg_data[CW_BITS-1:0];
					default: ;
				endcase
			end
			if (value_valid && value_ready)
				predict_chunks(value);
			if (chunk_valid && chunk_ready) begin
				if (chunk_q.size() == 0)
					report_mismatch("unexpected item, level", 64'd0, 64'(level));
				else begin
					want = chunk_q.pop_front();
					if (level !== want.level)
						report_mismatch("level", 64'(want.level), 64'(level));
					if (chunk !== want.chunk)
						report_mismatch("chunk", 64'(want.chunk), 64'(chunk));
					if (chunk_bits !== want.bits)
						report_mismatch("chunk_bits", 64'(want.bits), 64'(chunk_bits));
					if (has_mark !== want.has_mark)
						report_mismatch("has_mark", 64'(want.has_mark), 64'(has_mark));
					if (stop_mark !== want.stop_mark)
						report_mismatch("stop_mark", 64'(want.stop_mark), 64'(stop_mark));
					if (overflow !== want.overflow)
						report_mismatch("overflow", 64'(want.overflow), 64'(overflow));
					if (last !== want.last)
						report_mismatch("last", 64'(want.last), 64'(last));
				end
			end
			pending = chunk_q.size();
		end
	end

endmodule

// ===== bench/dacs_value_chunk_encoder_top_tb.sv =====
// Testbench top for the DACs value chunk encoder: clock, reset, register
// writes, value stimulus and chunk back-pressure, and the final verdict.
// Depends on dacs_pkg, dacs_value_chunk_encoder_top and dacs_chunk_checker.
`timescale 1ns / 1ps

module dacs_value_chunk_encoder_top_tb;
	import dacs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
	localparam int CYCLE_LIMIT = 300000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  value_valid = 1'b0;
	logic                  value_ready;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  chunk_valid;
	logic                  chunk_ready = 1'b0;
	logic [LVL_W-1:0]      level;
	logic [CHUNK_W-1:0]    chunk;
	logic [CW_FIELD-1:0]   chunk_bits;
	logic                  has_mark, stop_mark, overflow, last;
	int                    errors, pending;
	int                    cycles = 0;

	// stimulus-side view of the widths, used to aim values at level bases
	cw_t             cw_shadow = CW_RESET;
	int              quiet_in = 0;
	int              quiet_out = 0;

	dacs_value_chunk_encoder_top dut (.*);

	dacs_chunk_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dacs_value_chunk_encoder_top_tb: FAIL");
			$finish;
		end
	end

	// wait before the next item; occasional stretches with no waiting at all
	function automatic int draw_wait(inout int quiet);
		int gap;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 12) == 0)
			quiet = $urandom_range(4, 24);
		return gap;
	endfunction

	function automatic logic [63:0] level_base(int k);
		logic [63:0] b;
		int unsigned e;
		width_t      w;
		b = '0;
		e = 0;
		for (int i = 0; i < k; i++) begin
			w = cw_shadow[CW_FIELD*i +: CW_FIELD];
			e += (w == '0) ? 1 : w;
			if (e >= VALUE_BITS)
				return '1;
			b += 64'd1 << e;
		end
		return b;
	endfunction

	function automatic val_t pick_value();
		logic [63:0] b;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4, 5: begin
				b = level_base($urandom_range(1, MAX_LEVELS - 1));
				if (b > 64'hFFFF_FFFF)
					return $urandom;
				return val_t'(b - 64'd1 + $urandom_range(0, 3));
			end
			6: return val_t'('1) - $urandom_range(0, 7);
			7: return $urandom_range(0, 15);
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_value(val_t v);
		int gap;
		gap = draw_wait(quiet_in);
		if (gap > 0) begin
			@(negedge clk);
			value_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		value_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (!value_ready);
	endtask

	// leaves cfg_wr_en high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(logic [LC_W-1:0] lc, cw_t cw, bit with_spare);
		logic [CFG_DATA_W-1:0] data;
		@(negedge clk);
		value_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		data = CFG_DATA_W'({$urandom, $urandom});
		data[LC_W-1:0] = lc;
		write_reg(REG_LEVEL_COUNT, data);
		write_reg(REG_CHUNK_WIDTHS, cw);
		if (with_spare) begin
			write_reg(REG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}));
			write_reg(REG_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}));
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cw_shadow = cw;
	endtask

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_wait(quiet_out);
			if (stall > 0) begin
				@(negedge clk);
				chunk_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			chunk_ready <= 1'b1;
			do @(posedge clk); while (!chunk_valid);
		end
	end

	initial begin
		cw_t         cw;
		int          lc;
		logic [63:0] b;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset widths: extremes and both sides of every level base
		send_value('0);
		send_value('1);
		for (int k = 1; k < MAX_LEVELS; k++) begin
			b = level_base(k);
			if (b <= 64'hFFFF_FFFF) begin
				send_value(val_t'(b - 64'd1));
				send_value(val_t'(b));
			end
		end

		// widest chunks, level count saturating: level two is out of reach
		set_config(LC_W'(15), '1, 1'b0);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value('1);

		// level count zero runs as a single level, so the top chunk can overflow
		set_config('0, '1, 1'b0);
		send_value('1);
		send_value(32'h7FFF_FFFF);

		// zero width fields read as one bit; spare register indexes are ignored
		set_config(LC_W'(8), '0, 1'b1);
		send_value(32'd255);
		send_value(32'h0000_FFFF);

		for (int p = 0; p < 9; p++) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				case ($urandom_range(0, 5))
					0: cw[CW_FIELD*i +: CW_FIELD] = CW_FIELD'($urandom_range(0, 31));
					1: cw[CW_FIELD*i +: CW_FIELD] = '0;
					default: cw[CW_FIELD*i +: CW_FIELD] = CW_FIELD'($urandom_range(1, 6));
				endcase
			end
			lc = (p == 0) ? 1 : (p == 1) ? 8 : (p == 2) ? 15 : (p == 3) ? 0
				: $urandom_range(0, 15);
			set_config(LC_W'(lc), cw, p % 3 == 0);
			repeat (34) send_value(pick_value());
		end

		@(negedge clk);
		value_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (errors == 0)
			$display("dacs_value_chunk_encoder_top_tb: PASS");
		else
			$display("dacs_value_chunk_encoder_top_tb: FAIL");
		$finish;
	end

endmodule
